// ===== rtl/ultrasonic_range_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_SEQUENCER_DEFINES_SVH
`define ULTRASONIC_RANGE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define URS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urs assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define URS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urs assertion failed");
`else
`define URS_ASSERT_IMP(lbl, ante, cons)
`define URS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer package
// Shared widths, register indexes and the stage payload type.
// ----------------------------------------------------------------------------
package urs_pkg;

    // phase timer and echo counter width
    localparam int TIMER_WIDTH = 16;
    localparam int CMP_W       = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [CMP_W-1:0] TIMER_MAX = CMP_W'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [CMP_W-1:0] WIDTH_MAX = CMP_W'(16'hFFFF);

    // configuration register indexes
    localparam logic [2:0] CFG_TRIG_LOW  = 3'd0;
    localparam logic [2:0] CFG_TRIG_HIGH = 3'd1;
    localparam logic [2:0] CFG_HOLDOFF   = 3'd2;
    localparam logic [2:0] CFG_MAX_ECHO  = 3'd3;
    localparam logic [2:0] CFG_REST      = 3'd4;

    // reciprocal of ten, exact for dividends below 2^19
    localparam int          RECIP_SHIFT = 22;
    localparam logic [18:0] RECIP_TEN   = 19'd419431;

    // per-tick result before the distance is formed
    typedef struct packed {
        logic        level;
        logic        drive;
        logic        valid;
        logic [15:0] width;
        logic        timed_out;
    } tick_result_t;

endpackage

// ===== rtl/ultrasonic_range_sequencer.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer
// Trigger/echo sequencer for a ping range sensor, one transaction per 1 us tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, echo_level) carries one sampled echo
//   level per microsecond tick. Output channel (out_valid/out_ready) returns
//   one transaction per tick: pin level and drive, plus result_valid with
//   echo_width, distance (0.1 mm units) and timed_out on measurement ticks.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   it only while no ticks are in flight. Unknown indexes are ignored.
// Pipeline: an accepted tick is registered in the sequencer stage, then in
//   the distance stage with its constant reciprocal multiply.
// Throughput: one tick per cycle while out_ready is high; the phase state
//   updates once per accepted tick.
// Reset: phase returns to trigger low with cleared timer and echo count,
//   the registers take their defaults (2, 5, 750, 18500, 50000) and both
//   pipeline stages empty.
// Stall: when out_ready is low the output holds; the sequencer stage can
//   still take one tick, after which in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`include "ultrasonic_range_sequencer_defines.svh"

module ultrasonic_range_sequencer
    import urs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // tick input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        echo_level,
    // tick result
    output logic        out_valid,
    input  logic        out_ready,
    output logic        trigger_level,
    output logic        trigger_drive,
    output logic        result_valid,
    output logic [15:0] echo_width,
    output logic [16:0] distance,
    output logic        timed_out
);

    // phase codes
    localparam logic [2:0] PH_TLOW  = 3'd0;
    localparam logic [2:0] PH_THIGH = 3'd1;
    localparam logic [2:0] PH_HOLD  = 3'd2;
    localparam logic [2:0] PH_MEAS  = 3'd3;
    localparam logic [2:0] PH_REST  = 3'd4;

    // configuration registers
    logic [7:0]  trig_low_reg;
    logic [7:0]  trig_high_reg;
    logic [15:0] holdoff_reg;
    logic [15:0] max_echo_reg;
    logic [15:0] rest_reg;

    // sequencer state
    logic [2:0]             phase_reg,  phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg,  timer_next;
    logic [TIMER_WIDTH-1:0] count_reg,  count_next;

    // pipeline stages
    logic         s1_valid_reg;
    tick_result_t s1_reg, s1_next;
    logic         out_valid_reg;
    logic         level_reg, drive_reg, rvalid_reg, tmo_reg;
    logic [15:0]  width_reg;
    logic [16:0]  dist_reg;

    logic in_fire;
    logic s1_take;
    logic out_free;

    // clamped duration of a timed phase
    function automatic logic [CMP_W-1:0] phase_dur(
        input logic [2:0]  ph,
        input logic [7:0]  tl,
        input logic [7:0]  th,
        input logic [15:0] ho,
        input logic [15:0] re
    );
        logic [CMP_W-1:0] d;
        case (ph)
            PH_TLOW:  d = CMP_W'(tl);
            PH_THIGH: d = CMP_W'(th);
            PH_HOLD:  d = CMP_W'(ho);
            default:  d = CMP_W'(re);
        endcase
        return (d > TIMER_MAX) ? TIMER_MAX : d;
    endfunction

    function automatic logic [2:0] phase_succ(input logic [2:0] ph);
        logic [2:0] n;
        case (ph)
            PH_TLOW:  n = PH_THIGH;
            PH_THIGH: n = PH_HOLD;
            PH_HOLD:  n = PH_MEAS;
            PH_MEAS:  n = PH_REST;
            default:  n = PH_TLOW;
        endcase
        return n;
    endfunction

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s1_take  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg  <= 8'd2;
            trig_high_reg <= 8'd5;
            holdoff_reg   <= 16'd750;
            max_echo_reg  <= 16'd18500;
            rest_reg      <= 16'd50000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIG_LOW:  trig_low_reg  <= cfg_data[7:0];
                CFG_TRIG_HIGH: trig_high_reg <= cfg_data[7:0];
                CFG_HOLDOFF:   holdoff_reg   <= cfg_data;
                CFG_MAX_ECHO:  max_echo_reg  <= cfg_data;
                CFG_REST:      rest_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer step for one tick
    always_comb
    begin
        logic [2:0]       ph;
        logic [CMP_W-1:0] tm;
        logic [CMP_W-1:0] cnt;
        logic             done;
        logic             tmo;

        ph   = phase_reg;
        tm   = CMP_W'(timer_reg);
        cnt  = CMP_W'(count_reg);
        done = 1'b0;
        tmo  = 1'b0;

        // skip finished or zero-length timed phases
        for (int i = 0; i < 5; i++)
        begin
            if (ph != PH_MEAS &&
                tm >= phase_dur(ph, trig_low_reg, trig_high_reg, holdoff_reg, rest_reg))
            begin
                ph = phase_succ(ph);
                tm = '0;
            end
        end

        s1_next = '0;

        if (ph == PH_MEAS)
        begin
            if (echo_level)
            begin
                if (cnt < TIMER_MAX)
                    cnt = cnt + CMP_W'(1);
                if (cnt > CMP_W'(max_echo_reg) || cnt == TIMER_MAX)
                begin
                    tmo  = 1'b1;
                    done = 1'b1;
                end
            end
            else
            begin
                done = 1'b1;
            end

            if (done)
            begin
                s1_next.valid     = 1'b1;
                s1_next.timed_out = tmo;
                s1_next.width     = (cnt > WIDTH_MAX) ? 16'hFFFF : cnt[15:0];
                ph  = PH_REST;
                tm  = '0;
                cnt = '0;
            end
        end
        else
        begin
            s1_next.drive = (ph == PH_TLOW) || (ph == PH_THIGH) || (ph == PH_HOLD);
            s1_next.level = (ph == PH_THIGH);
            if (tm < TIMER_MAX)
                tm = tm + CMP_W'(1);
        end

        phase_next = ph;
        timer_next = tm[TIMER_WIDTH-1:0];
        count_next = cnt[TIMER_WIDTH-1:0];
    end

    // sequencer state and first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TLOW;
            timer_reg    <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                count_reg <= count_next;
            end
            s1_valid_reg <= in_fire || (s1_valid_reg && !s1_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_reg <= s1_next;
    end

    // distance = w + floor(7w/10), division by reciprocal multiply
    logic [18:0] w7;
    logic [37:0] q_prod;
    logic [16:0] dist_next;

    assign w7        = {s1_reg.width, 3'b000} - 19'(s1_reg.width);
    assign q_prod    = 38'(w7) * 38'(RECIP_TEN);
    assign dist_next = 17'(s1_reg.width) + 17'(q_prod >> RECIP_SHIFT);

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            level_reg  <= s1_reg.level;
            drive_reg  <= s1_reg.drive;
            rvalid_reg <= s1_reg.valid;
            tmo_reg    <= s1_reg.timed_out;
            width_reg  <= s1_reg.width;
            dist_reg   <= dist_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = level_reg;
    assign trigger_drive = drive_reg;
    assign result_valid  = rvalid_reg;
    assign echo_width    = width_reg;
    assign distance      = dist_reg;
    assign timed_out     = tmo_reg;

    // checks
    `URS_ASSERT_IMP(a_count_only_measuring, count_reg != '0, phase_reg == PH_MEAS)
    `URS_ASSERT_IMP(a_result_pin_released, s1_valid_reg && s1_reg.valid,
                    !s1_reg.drive && !s1_reg.level)
    `URS_ASSERT_IMP(a_timeout_has_width, out_valid_reg && tmo_reg,
                    rvalid_reg && width_reg != 16'd0 && dist_reg >= 17'(width_reg))

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer testbench
// Feeds echo ticks through the valid/ready input channel and checks every tick
// result against a cycle-free predictor of the trigger/holdoff/measure/rest
// sequence. A directed table covers reset behavior, zero-length phases, echo
// already low and timeouts. Randomized setting phases with sensor-like echo
// pulses follow, then a short run at the register extremes.
// ----------------------------------------------------------------------------
module testbench;
    import urs_pkg::*;

    localparam int unsigned TMR_TOP       = (1 << TIMER_WIDTH) - 1;
    localparam logic [2:0]  CFG_SPARE     = 3'd7;
    localparam int          LONG_STALL    = 200;
    localparam int          SETTLE        = 6;
    localparam int          RANDOM_PHASES = 18;
    localparam int          PHASE_TICKS   = 100;
    localparam int          EXTREME_TICKS = 150;

    typedef enum logic [2:0] {
        SEQ_TRIG_LOW,
        SEQ_TRIG_HIGH,
        SEQ_HOLDOFF,
        SEQ_MEASURE,
        SEQ_REST
    } seq_phase_e;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_CADENCE, RX_CHOKED} rx_mode_e;

    // one tick result, in port order
    typedef struct packed {
        logic        trig_level;
        logic        trig_drive;
        logic        meas_valid;
        logic [15:0] width;
        logic [16:0] range_val;
        logic        tmo;
    } tick_out_t;

    typedef struct {
        bit          is_write;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        bit          echo;
        bit          typed;
        tick_out_t   want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        echo_level;
    logic        out_valid;
    logic        out_ready;
    logic        trigger_level;
    logic        trigger_drive;
    logic        result_valid;
    logic [15:0] echo_width;
    logic [16:0] distance;
    logic        timed_out;

    // predictor state and its copy of the registers
    seq_phase_e           seq_phase     = SEQ_TRIG_LOW;
    bit [TIMER_WIDTH-1:0] phase_tmr     = '0;
    bit [TIMER_WIDTH-1:0] echo_cnt      = '0;
    bit [7:0]             trig_low_len  = 8'd2;
    bit [7:0]             trig_high_len = 8'd5;
    bit [15:0]            holdoff_len   = 16'd750;
    bit [15:0]            max_echo_len  = 16'd18500;
    bit [15:0]            rest_len      = 16'd50000;

    tick_out_t expected_pin_results[$];

    int errors       = 0;
    int ticks_sent   = 0;
    int measurements = 0;
    int timeouts     = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    bit stall_request = 1'b0;

    ultrasonic_range_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .trigger_level (trigger_level),
        .trigger_drive (trigger_drive),
        .result_valid  (result_valid),
        .echo_width    (echo_width),
        .distance      (distance),
        .timed_out     (timed_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("timeout with %0d results still pending", expected_pin_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function automatic string show(input tick_out_t r);
        return $sformatf("lvl=%0d drv=%0d vld=%0d width=%0d dist=%0d tmo=%0d",
                         r.trig_level, r.trig_drive, r.meas_valid, r.width, r.range_val,
                         r.tmo);
    endfunction

    function automatic tick_out_t pin(input int lvl, input int drv, input int vld,
                                      input int w, input int d, input int t);
        tick_out_t r;
        r.trig_level = lvl[0];
        r.trig_drive = drv[0];
        r.meas_valid = vld[0];
        r.width      = w[15:0];
        r.range_val  = d[16:0];
        r.tmo        = t[0];
        return r;
    endfunction

    function automatic stim_row_t tick_row(input bit e);
        stim_row_t row;
        row = '{default: '0};
        row.echo = e;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input bit e, input tick_out_t want);
        stim_row_t row;
        row = tick_row(e);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [15:0] val);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        return row;
    endfunction

    // one microsecond tick of the sequencer
    function automatic tick_out_t sequence_tick(input bit echo);
        tick_out_t   r;
        int unsigned len;
        int          n;
        bit          done;
        r = '0;
        // skip phases that are complete or have zero length
        for (n = 0; n < 5; n++)
        begin
            case (seq_phase)
                SEQ_TRIG_LOW:  len = trig_low_len;
                SEQ_TRIG_HIGH: len = trig_high_len;
                SEQ_HOLDOFF:   len = holdoff_len;
                default:       len = rest_len;
            endcase
            if (len > TMR_TOP)
                len = TMR_TOP;
            if (seq_phase == SEQ_MEASURE || phase_tmr < len)
                break;
            case (seq_phase)
                SEQ_TRIG_LOW:  seq_phase = SEQ_TRIG_HIGH;
                SEQ_TRIG_HIGH: seq_phase = SEQ_HOLDOFF;
                SEQ_HOLDOFF:   seq_phase = SEQ_MEASURE;
                default:       seq_phase = SEQ_TRIG_LOW;
            endcase
            phase_tmr = '0;
        end

        if (seq_phase == SEQ_MEASURE)
        begin
            done = 1'b0;
            if (echo)
            begin
                if (echo_cnt != '1)
                    echo_cnt++;
                if (echo_cnt > max_echo_len || echo_cnt == '1)
                begin
                    r.tmo = 1'b1;
                    done  = 1'b1;
                end
            end
            else
                done = 1'b1;
            if (done)
            begin
                r.meas_valid = 1'b1;
                r.width      = (echo_cnt > 'hFFFF) ? 16'hFFFF : 16'(echo_cnt);
                r.range_val  = 17'((32'(r.width) * 17) / 10);
                seq_phase    = SEQ_REST;
                phase_tmr    = '0;
                echo_cnt     = '0;
            end
        end
        else
        begin
            r.trig_drive = (seq_phase != SEQ_REST);
            r.trig_level = (seq_phase == SEQ_TRIG_HIGH);
            if (phase_tmr != '1)
                phase_tmr++;
        end
        return r;
    endfunction

    // one input transaction, sometimes preceded by a gap when a burst runs out and gaps are on
    task automatic offer_tick(input bit e, input bit typed, input tick_out_t want);
        tick_out_t predicted;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        echo_level <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = sequence_tick(e);
        expected_pin_results.push_back(typed ? want : predicted);
        ticks_sent++;
        @(negedge clk);
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pin_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TRIG_LOW:  trig_low_len  = val[7:0];
            CFG_TRIG_HIGH: trig_high_len = val[7:0];
            CFG_HOLDOFF:   holdoff_len   = val;
            CFG_MAX_ECHO:  max_echo_len  = val;
            CFG_REST:      rest_len      = val;
            default:       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        tick_out_t got;
        tick_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {trigger_level, trigger_drive, result_valid, echo_width, distance, timed_out};
            if (expected_pin_results.size() == 0)
                note_error($sformatf("result with nothing pending: %s", show(got)));
            else
            begin
                want = expected_pin_results.pop_front();
                if (got.trig_level != want.trig_level || got.trig_drive != want.trig_drive ||
                    got.meas_valid != want.meas_valid || got.width != want.width ||
                    got.range_val != want.range_val || got.tmo != want.tmo)
                    note_error($sformatf("expected %s, got %s", show(want), show(got)));
                else if (got.meas_valid)
                begin
                    measurements++;
                    if (got.tmo)
                        timeouts++;
                end
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off on request
    initial
    begin
        rx_mode_e rx_mode;
        int       rx_left;
        int       rx_cycle;
        int       hold;
        rx_mode   = RX_OPEN;
        rx_left   = 0;
        rx_cycle  = 0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                for (hold = 0; hold < LONG_STALL; hold++)
                    @(negedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_e'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 128);
                end
                rx_left--;
                rx_cycle++;
                case (rx_mode)
                    RX_OPEN:    out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                    RX_CADENCE: out_ready <= (rx_cycle % 3 != 0);
                    default:    out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        int        p;
        int        t;
        int        run_left;
        bit        echo_now;
        bit        e;
        int        r;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_TRIG_LOW;
        cfg_data   = '0;
        in_valid   = 1'b0;
        echo_level = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default settings out of reset: two low, five high, then holdoff
        rows.push_back(typed_row(1'b0, pin(0, 1, 0, 0, 0, 0)));
        rows.push_back(typed_row(1'b0, pin(0, 1, 0, 0, 0, 0)));
        repeat (5) rows.push_back(typed_row(1'b0, pin(1, 1, 0, 0, 0, 0)));
        rows.push_back(typed_row(1'b0, pin(0, 1, 0, 0, 0, 0)));
        // every timed phase zero length, trigger pulse included
        rows.push_back(reg_row(CFG_TRIG_LOW, 16'd0));
        rows.push_back(reg_row(CFG_TRIG_HIGH, 16'd0));
        rows.push_back(reg_row(CFG_HOLDOFF, 16'd0));
        rows.push_back(reg_row(CFG_MAX_ECHO, 16'd3));
        rows.push_back(reg_row(CFG_REST, 16'd0));
        // echo already low when measuring starts
        rows.push_back(typed_row(1'b0, pin(0, 0, 1, 0, 0, 0)));
        // timeout reports max plus one
        repeat (3) rows.push_back(typed_row(1'b1, pin(0, 0, 0, 0, 0, 0)));
        rows.push_back(typed_row(1'b1, pin(0, 0, 1, 4, 6, 1)));
        rows.push_back(tick_row(1'b1));
        rows.push_back(tick_row(1'b0));
        // unknown index is ignored
        rows.push_back(reg_row(CFG_SPARE, 16'hFFFF));
        rows.push_back(reg_row(CFG_MAX_ECHO, 16'd1));
        rows.push_back(reg_row(CFG_TRIG_HIGH, 16'd1));
        rows.push_back(reg_row(CFG_REST, 16'd1));
        repeat (4) rows.push_back(tick_row(1'b1));
        repeat (2) rows.push_back(tick_row(1'b0));

        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                drain();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                offer_tick(rows[i].echo, rows[i].typed, rows[i].want);
        end

        // random setting phases with sensor-like echo pulses and some noise
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            r = $urandom_range(0, 9);
            write_reg(CFG_TRIG_LOW, (r == 0) ? 16'd255 : 16'($urandom_range(0, 3)));
            r = $urandom_range(0, 9);
            write_reg(CFG_TRIG_HIGH, (r == 0) ? 16'd0 : (r == 1) ? 16'd255 :
                                     16'($urandom_range(1, 4)));
            write_reg(CFG_HOLDOFF, 16'($urandom_range(0, 6)));
            r = $urandom_range(0, 7);
            write_reg(CFG_MAX_ECHO, (r == 0) ? 16'd1 : 16'($urandom_range(2, 20)));
            write_reg(CFG_REST, 16'($urandom_range(0, 6)));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_REST + 3'($urandom_range(1, 3)), 16'($urandom));

            // one phase runs back to back into a long output hold-off
            gaps_on = (p != 3);
            if (p == 3)
                stall_request = 1'b1;
            run_left = 0;
            echo_now = 1'b0;
            for (t = 0; t < PHASE_TICKS; t++)
            begin
                if (p == 7 && t == PHASE_TICKS / 2)
                    drain();
                if (run_left == 0)
                begin
                    echo_now = !echo_now;
                    run_left = echo_now ? $urandom_range(1, max_echo_len + 3)
                                        : $urandom_range(1, 5);
                end
                run_left--;
                e = echo_now;
                if ($urandom_range(0, 15) == 0)
                    e = !e;
                offer_tick(e, 1'b0, '0);
            end
        end

        // register extremes: longest phases, echo held high
        drain();
        write_reg(CFG_TRIG_LOW, 16'd255);
        write_reg(CFG_TRIG_HIGH, 16'd255);
        write_reg(CFG_HOLDOFF, 16'hFFFF);
        write_reg(CFG_MAX_ECHO, 16'hFFFE);
        write_reg(CFG_REST, 16'hFFFF);
        gaps_on = 1'b0;
        for (t = 0; t < EXTREME_TICKS; t++)
            offer_tick(1'b1, 1'b0, '0);

        drain();
        if (expected_pin_results.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_pin_results.size()));
        $display("ran %0d ticks over %0d register settings", ticks_sent, RANDOM_PHASES + 3);
        $display("checked %0d measurements, %0d ending in timeout", measurements, timeouts);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
